>>> design/gbi_pkg.sv
package gbi_pkg;

	localparam int MAX_COLS_DEF = 256;
	localparam int MAX_ROWS_DEF = 256;

	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 16;
	localparam int STORE_DEPTH = 65536;
	localparam int CFG_IDX_W   = 3;
	localparam int WGT_W       = 48;
	localparam int ACC_W       = 128;
	localparam int DEN_W       = 62;
	localparam int MUL_CNT_W   = 6;
	localparam int DIV_CNT_W   = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_COLS = 3'd0,
		CFG_NUM_ROWS = 3'd1,
		CFG_X_ORIGIN = 3'd2,
		CFG_Y_ORIGIN = 3'd3,
		CFG_X_STEP   = 3'd4,
		CFG_Y_STEP   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [8:0]  num_cols;
		logic [8:0]  num_rows;
		logic [31:0] x_origin;
		logic [31:0] y_origin;
		logic [30:0] x_step;
		logic [30:0] y_step;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] cell_index;
		logic [31:0] cell_value;
		logic [31:0] query_x;
		logic [31:0] query_y;
	} item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DIVX,
		ST_DIVX_W,
		ST_DIVY,
		ST_DIVY_W,
		ST_PROD,
		ST_WGT,
		ST_RD,
		ST_RD_W,
		ST_MUL1,
		ST_MUL1_W,
		ST_MUL2,
		ST_MUL2_W,
		ST_MAG,
		ST_DIVF,
		ST_DIVF_W,
		ST_RND,
		ST_OUT
	} state_t;

endpackage

>>> design/gbi_ram.sv
module gbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/gbi_mul.sv
module gbi_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [gbi_pkg::ACC_W-1:0]      a,
	input  logic [gbi_pkg::WGT_W-1:0]      b,
	input  logic [gbi_pkg::MUL_CNT_W-1:0]  iters,
	output logic                           done,
	output logic [gbi_pkg::ACC_W-1:0]      prod
);

	logic                          run_q;
	logic                          done_q;
	logic [gbi_pkg::MUL_CNT_W-1:0] cnt_q;
	logic [gbi_pkg::ACC_W-1:0]     a_q;
	logic [gbi_pkg::WGT_W-1:0]     b_q;
	logic [gbi_pkg::ACC_W-1:0]     p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
		end else if (run_q) begin
			cnt_q  <= cnt_q - 1'b1;
			run_q  <= (cnt_q != gbi_pkg::MUL_CNT_W'(1));
			done_q <= (cnt_q == gbi_pkg::MUL_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift-add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (run_q) begin
			p_q <= p_q + (b_q[0] ? a_q : '0);
			a_q <= {a_q[gbi_pkg::ACC_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[gbi_pkg::WGT_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

>>> design/gbi_div.sv
module gbi_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [gbi_pkg::ACC_W-1:0]      num,
	input  logic [gbi_pkg::DEN_W-1:0]      den,
	input  logic [gbi_pkg::DIV_CNT_W-1:0]  iters,
	output logic                           done,
	output logic [gbi_pkg::ACC_W-1:0]      quo,
	output logic [gbi_pkg::DEN_W-1:0]      rem
);

	logic                          run_q;
	logic                          done_q;
	logic [gbi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [gbi_pkg::ACC_W-1:0]     n_q;
	logic [gbi_pkg::DEN_W-1:0]     r_q;
	logic [gbi_pkg::DEN_W-1:0]     d_q;
	logic [gbi_pkg::DEN_W:0]       rs;
	logic [gbi_pkg::DEN_W:0]       diff;
	logic                          ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
		end else if (run_q) begin
			cnt_q  <= cnt_q - 1'b1;
			run_q  <= (cnt_q != gbi_pkg::DIV_CNT_W'(1));
			done_q <= (cnt_q == gbi_pkg::DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// restoring division: bring down one numerator bit, shift the quotient bit in
	always_comb begin
		rs   = {r_q, n_q[gbi_pkg::ACC_W-1]};
		diff = rs - {1'b0, d_q};
		ge   = (rs >= {1'b0, d_q});
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			n_q <= {n_q[gbi_pkg::ACC_W-2:0], ge};
			r_q <= ge ? diff[gbi_pkg::DEN_W-1:0] : rs[gbi_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = n_q;
	assign rem  = r_q;

endmodule

>>> design/gbi_front.sv
module gbi_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gbi_pkg::item_t item,
	output logic           head_valid,
	output gbi_pkg::item_t head,
	input  logic           pop
);

	localparam int PTR_W = $clog2(gbi_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(gbi_pkg::QUEUE_DEPTH + 1);

	gbi_pkg::item_t   mem_q [gbi_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             take;

	assign busy       = (cnt_q == CNT_W'(gbi_pkg::QUEUE_DEPTH));
	assign push       = start && !busy;
	assign head_valid = (cnt_q != '0);
	assign take       = pop && head_valid;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

endmodule

>>> design/gbi_back.sv
module gbi_back #(
	parameter int MAX_COLS = gbi_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = gbi_pkg::MAX_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gbi_pkg::cfg_t               cfg,
	input  logic                        head_valid,
	input  gbi_pkg::item_t              head,
	output logic                        pop,
	output logic                        done,
	output logic [gbi_pkg::DATA_W-1:0]  interp_value,
	output logic                        was_clamped
);

	localparam int IDX_W = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS);
	localparam int NC_W  = IDX_W + 1;
	localparam int PR_W  = IDX_W + 31;
	localparam int BF_W  = 2 * IDX_W + 1;
	localparam int ACC_W = gbi_pkg::ACC_W;
	localparam int WGT_W = gbi_pkg::WGT_W;

	function automatic logic [WGT_W-1:0] mag_w(input logic [WGT_W-1:0] v);
		return v[WGT_W-1] ? (~v + 1'b1) : v;
	endfunction

	gbi_pkg::state_t state_q, state_d;

	// effective configuration
	logic [IDX_W-1:0] ncm1, nrm1;
	logic [NC_W-1:0]  nc_full;
	logic [30:0]      sx, sy;

	always_comb begin
		if (cfg.num_cols < 9'd2) begin
			ncm1 = IDX_W'(1);
		end else if (32'(cfg.num_cols) > 32'(MAX_COLS)) begin
			ncm1 = IDX_W'(MAX_COLS - 1);
		end else begin
			ncm1 = IDX_W'(cfg.num_cols - 9'd1);
		end
		if (cfg.num_rows < 9'd2) begin
			nrm1 = IDX_W'(1);
		end else if (32'(cfg.num_rows) > 32'(MAX_ROWS)) begin
			nrm1 = IDX_W'(MAX_ROWS - 1);
		end else begin
			nrm1 = IDX_W'(cfg.num_rows - 9'd1);
		end
		nc_full = NC_W'(ncm1) + 1'b1;
		sx = (cfg.x_step == '0) ? 31'd1 : cfg.x_step;
		sy = (cfg.y_step == '0) ? 31'd1 : cfg.y_step;
	end

	// datapath registers
	logic [31:0]             qx_q, qy_q;
	logic [32:0]             dx_q, dy_q;
	logic [IDX_W-1:0]        i0_q, j0_q;
	logic                    out_q;
	logic [PR_W-1:0]         i0sx_q, j0sy_q;
	logic [gbi_pkg::ADDR_W-1:0] base_q;
	logic [gbi_pkg::DEN_W-1:0]  den_q;
	logic [WGT_W-1:0]        wx0_q, wx1_q, wy0_q, wy1_q;
	logic [1:0]              k_q;
	logic [31:0]             v_q [4];
	logic [ACC_W-1:0]        t_q;
	logic                    tneg_q;
	logic [ACC_W-1:0]        acc_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        quo_q;
	logic                    done_q;
	logic [31:0]             value_q;
	logic                    clamp_q;

	// shared units
	logic                            div_go, div_done;
	logic [ACC_W-1:0]                div_num, div_quo;
	logic [gbi_pkg::DEN_W-1:0]       div_den, div_rem;
	logic [gbi_pkg::DIV_CNT_W-1:0]   div_iters;
	logic                            mul_go, mul_done;
	logic [ACC_W-1:0]                mul_a, mul_prod;
	logic [WGT_W-1:0]                mul_b;
	logic [gbi_pkg::MUL_CNT_W-1:0]   mul_iters;
	logic                            ram_we;
	logic [gbi_pkg::ADDR_W-1:0]      ram_raddr;
	logic [gbi_pkg::DATA_W-1:0]      ram_rdata;

	gbi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.num   (div_num),
		.den   (div_den),
		.iters (div_iters),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	gbi_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.a     (mul_a),
		.b     (mul_b),
		.iters (mul_iters),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	gbi_ram #(
		.WIDTH(gbi_pkg::DATA_W),
		.DEPTH(gbi_pkg::STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head.cell_index),
		.wdata(head.cell_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// bracket one axis from the quotient of the offset by the step
	logic             axis_y;
	logic             ax_neg, rnz, outside;
	logic [IDX_W-1:0] nm1, lo, hi, idx;
	logic signed [34:0] qs, fl, ce, nm1s, rnzs;

	always_comb begin
		axis_y  = (state_q == gbi_pkg::ST_DIVY_W);
		ax_neg  = axis_y ? dy_q[32] : dx_q[32];
		nm1     = axis_y ? nrm1 : ncm1;
		rnz     = (div_rem != '0);
		qs      = $signed({2'b00, div_quo[32:0]});
		rnzs    = $signed(35'(rnz));
		nm1s    = $signed(35'(nm1));
		fl      = ax_neg ? (-qs - rnzs) : qs;
		ce      = ax_neg ? -qs : (qs + rnzs);
		outside = (fl < 35'sd0) || (ce > nm1s);
		if (fl < 35'sd0) begin
			lo = '0;
		end else if (fl > nm1s) begin
			lo = nm1;
		end else begin
			lo = fl[IDX_W-1:0];
		end
		if (ce < 35'sd0) begin
			hi = '0;
		end else if (ce > nm1s) begin
			hi = nm1;
		end else begin
			hi = ce[IDX_W-1:0];
		end
		// widen a degenerate pair: upward at the first index, downward elsewhere
		idx = ((lo == hi) && (lo != '0)) ? (hi - 1'b1) : lo;
	end

	// corner selection
	logic [WGT_W-1:0] wx_sel, wy_sel;
	logic [31:0]      v_sel, v_mag;
	logic             p_neg;
	logic [BF_W-1:0]  base_full;
	logic [32:0]      dmag;
	logic [WGT_W-1:0] wx1_n, wy1_n;

	always_comb begin
		wx_sel    = k_q[0] ? wx1_q : wx0_q;
		wy_sel    = k_q[1] ? wy1_q : wy0_q;
		v_sel     = v_q[k_q];
		v_mag     = v_sel[31] ? (~v_sel + 1'b1) : v_sel;
		p_neg     = tneg_q ^ v_sel[31];
		ram_raddr = base_q + gbi_pkg::ADDR_W'(k_q[0])
			+ (k_q[1] ? gbi_pkg::ADDR_W'(nc_full) : '0);
		base_full = BF_W'(j0_q) * BF_W'(nc_full) + BF_W'(i0_q);
		dmag      = (state_q == gbi_pkg::ST_DIVY)
			? (dy_q[32] ? (~dy_q + 1'b1) : dy_q)
			: (dx_q[32] ? (~dx_q + 1'b1) : dx_q);
		wx1_n     = {{(WGT_W-33){dx_q[32]}}, dx_q} - WGT_W'(i0sx_q);
		wy1_n     = {{(WGT_W-33){dy_q[32]}}, dy_q} - WGT_W'(j0sy_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbi_pkg::ST_IDLE: begin
				if (head_valid && (head.mode == gbi_pkg::MODE_QUERY)) begin
					state_d = gbi_pkg::ST_DIFF;
				end
			end
			gbi_pkg::ST_DIFF:   state_d = gbi_pkg::ST_DIVX;
			gbi_pkg::ST_DIVX:   state_d = gbi_pkg::ST_DIVX_W;
			gbi_pkg::ST_DIVX_W: begin
				if (div_done) begin
					state_d = gbi_pkg::ST_DIVY;
				end
			end
			gbi_pkg::ST_DIVY:   state_d = gbi_pkg::ST_DIVY_W;
			gbi_pkg::ST_DIVY_W: begin
				if (div_done) begin
					state_d = gbi_pkg::ST_PROD;
				end
			end
			gbi_pkg::ST_PROD:   state_d = gbi_pkg::ST_WGT;
			gbi_pkg::ST_WGT:    state_d = gbi_pkg::ST_RD;
			gbi_pkg::ST_RD:     state_d = gbi_pkg::ST_RD_W;
			gbi_pkg::ST_RD_W:   state_d = (k_q == 2'd3) ? gbi_pkg::ST_MUL1 : gbi_pkg::ST_RD;
			gbi_pkg::ST_MUL1:   state_d = gbi_pkg::ST_MUL1_W;
			gbi_pkg::ST_MUL1_W: begin
				if (mul_done) begin
					state_d = gbi_pkg::ST_MUL2;
				end
			end
			gbi_pkg::ST_MUL2:   state_d = gbi_pkg::ST_MUL2_W;
			gbi_pkg::ST_MUL2_W: begin
				if (mul_done) begin
					state_d = (k_q == 2'd3) ? gbi_pkg::ST_MAG : gbi_pkg::ST_MUL1;
				end
			end
			gbi_pkg::ST_MAG:    state_d = gbi_pkg::ST_DIVF;
			gbi_pkg::ST_DIVF:   state_d = gbi_pkg::ST_DIVF_W;
			gbi_pkg::ST_DIVF_W: begin
				if (div_done) begin
					state_d = gbi_pkg::ST_RND;
				end
			end
			gbi_pkg::ST_RND:    state_d = gbi_pkg::ST_OUT;
			gbi_pkg::ST_OUT:    state_d = gbi_pkg::ST_IDLE;
			default:            state_d = gbi_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		div_go    = 1'b0;
		div_num   = {dmag, {(ACC_W-33){1'b0}}};
		div_den   = gbi_pkg::DEN_W'(sx);
		div_iters = gbi_pkg::DIV_CNT_W'(33);
		mul_go    = 1'b0;
		mul_a     = ACC_W'(mag_w(wx_sel));
		mul_b     = mag_w(wy_sel);
		mul_iters = gbi_pkg::MUL_CNT_W'(WGT_W);
		case (state_q)
			gbi_pkg::ST_IDLE: begin
				pop    = head_valid;
				ram_we = head_valid && (head.mode == gbi_pkg::MODE_LOAD);
			end
			gbi_pkg::ST_DIVX: begin
				div_go = 1'b1;
			end
			gbi_pkg::ST_DIVY: begin
				div_go  = 1'b1;
				div_den = gbi_pkg::DEN_W'(sy);
			end
			gbi_pkg::ST_MUL1: begin
				mul_go = 1'b1;
			end
			gbi_pkg::ST_MUL2: begin
				mul_go    = 1'b1;
				mul_a     = t_q;
				mul_b     = WGT_W'(v_mag);
				mul_iters = gbi_pkg::MUL_CNT_W'(32);
			end
			gbi_pkg::ST_DIVF: begin
				div_go    = 1'b1;
				div_num   = acc_q;
				div_den   = den_q;
				div_iters = gbi_pkg::DIV_CNT_W'(ACC_W);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbi_pkg::ST_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == gbi_pkg::ST_OUT);
			if (state_q == gbi_pkg::ST_WGT) begin
				k_q <= '0;
			end else if ((state_q == gbi_pkg::ST_RD_W)
					|| ((state_q == gbi_pkg::ST_MUL2_W) && mul_done)) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// saturate and round the final quotient
	logic        sat;
	logic [31:0] limit;

	always_comb begin
		limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		sat   = (quo_q[ACC_W-1:32] != '0) || (quo_q[31:0] > limit);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gbi_pkg::ST_IDLE: begin
				qx_q  <= head.query_x;
				qy_q  <= head.query_y;
				out_q <= 1'b0;
				acc_q <= '0;
			end
			gbi_pkg::ST_DIFF: begin
				dx_q <= {qx_q[31], qx_q} - {cfg.x_origin[31], cfg.x_origin};
				dy_q <= {qy_q[31], qy_q} - {cfg.y_origin[31], cfg.y_origin};
			end
			gbi_pkg::ST_DIVX_W: begin
				if (div_done) begin
					i0_q  <= idx;
					out_q <= outside;
				end
			end
			gbi_pkg::ST_DIVY_W: begin
				if (div_done) begin
					j0_q  <= idx;
					out_q <= out_q | outside;
				end
			end
			gbi_pkg::ST_PROD: begin
				i0sx_q <= PR_W'(i0_q) * PR_W'(sx);
				j0sy_q <= PR_W'(j0_q) * PR_W'(sy);
				base_q <= gbi_pkg::ADDR_W'(base_full);
				den_q  <= gbi_pkg::DEN_W'(sx) * gbi_pkg::DEN_W'(sy);
			end
			gbi_pkg::ST_WGT: begin
				wx1_q <= wx1_n;
				wx0_q <= WGT_W'(sx) - wx1_n;
				wy1_q <= wy1_n;
				wy0_q <= WGT_W'(sy) - wy1_n;
			end
			gbi_pkg::ST_RD_W: begin
				v_q[k_q] <= ram_rdata;
			end
			gbi_pkg::ST_MUL1: begin
				tneg_q <= wx_sel[WGT_W-1] ^ wy_sel[WGT_W-1];
			end
			gbi_pkg::ST_MUL1_W: begin
				if (mul_done) begin
					t_q <= mul_prod;
				end
			end
			gbi_pkg::ST_MUL2_W: begin
				if (mul_done) begin
					// add or subtract the corner term with one carry-in
					acc_q <= acc_q + (p_neg ? ~mul_prod : mul_prod) + ACC_W'(p_neg);
				end
			end
			gbi_pkg::ST_MAG: begin
				neg_q <= acc_q[ACC_W-1];
				acc_q <= acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
			end
			gbi_pkg::ST_RND: begin
				// round toward minus infinity for negative sums
				quo_q <= div_quo + ACC_W'(neg_q && (div_rem != '0));
			end
			gbi_pkg::ST_OUT: begin
				if (sat) begin
					value_q <= limit;
				end else begin
					value_q <= neg_q ? (~quo_q[31:0] + 1'b1) : quo_q[31:0];
				end
				clamp_q <= out_q | sat;
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign interp_value = value_q;
	assign was_clamped  = clamp_q;

endmodule

>>> design/grid_bilinear_interpolator.sv
// Bilinear interpolation over a row-major grid of signed Q16.16 samples held in a
// 64K x 32 store. Pulse start while busy is low to transfer one item: mode 0 writes
// cell_value at cell_index and gives no result; mode 1 interpolates at (query_x,
// query_y) and later raises done for exactly one cycle with interp_value and
// was_clamped, which must be taken in that cycle since the block cannot hold a
// result. Up to two items queue ahead of the sequencer. A load is written to the
// store straight from the queue head while the sequencer idles; a query runs on the
// bit-serial divider (two 33-step axis divisions and one 128-step final division)
// and the bit-serial multiplier (four 48-step weight products and four 32-step
// sample products). Write configuration only while no query is in flight.
module grid_bilinear_interpolator #(
	parameter int MAX_COLS = gbi_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = gbi_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [15:0]                     cell_index,
	input  logic signed [31:0]              cell_value,
	input  logic signed [31:0]              query_x,
	input  logic signed [31:0]              query_y,
	output logic                            done,
	output logic signed [31:0]              interp_value,
	output logic                            was_clamped,
	input  logic                            cfg_we,
	input  logic [gbi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);

	gbi_pkg::cfg_t  cfg_q;
	gbi_pkg::item_t item;
	gbi_pkg::item_t head;
	logic           head_valid;
	logic           pop;
	logic [31:0]    value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_cols <= 9'd256;
			cfg_q.num_rows <= 9'd256;
			cfg_q.x_origin <= '0;
			cfg_q.y_origin <= '0;
			cfg_q.x_step   <= 31'd65536;
			cfg_q.y_step   <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				gbi_pkg::CFG_NUM_COLS: cfg_q.num_cols <= cfg_data[8:0];
				gbi_pkg::CFG_NUM_ROWS: cfg_q.num_rows <= cfg_data[8:0];
				gbi_pkg::CFG_X_ORIGIN: cfg_q.x_origin <= cfg_data;
				gbi_pkg::CFG_Y_ORIGIN: cfg_q.y_origin <= cfg_data;
				gbi_pkg::CFG_X_STEP:   cfg_q.x_step   <= cfg_data[30:0];
				gbi_pkg::CFG_Y_STEP:   cfg_q.y_step   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	assign item.mode       = mode;
	assign item.cell_index = cell_index;
	assign item.cell_value = cell_value;
	assign item.query_x    = query_x;
	assign item.query_y    = query_y;

	gbi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	gbi_back #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.done        (done),
		.interp_value(value),
		.was_clamped (was_clamped)
	);

	assign interp_value = $signed(value);

endmodule

>>> tb/tb_top.sv
module tb_top;
	import gbi_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX_B = 3'd7;
	localparam int GRID_CELL_CAP = 600;

	typedef struct {
		logic signed [31:0] value;
		logic               clamped;
	} interp_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 mode = MODE_LOAD;
	logic [15:0]          cell_index = '0;
	logic signed [31:0]   cell_value = '0;
	logic signed [31:0]   query_x = '0;
	logic signed [31:0]   query_y = '0;
	logic                 done;
	logic signed [31:0]   interp_value;
	logic                 was_clamped;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	grid_bilinear_interpolator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.cell_index(cell_index), .cell_value(cell_value), .query_x(query_x),
		.query_y(query_y), .done(done), .interp_value(interp_value),
		.was_clamped(was_clamped), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the grid and configuration
	logic signed [31:0] grid_mem [0:STORE_DEPTH-1];
	logic [8:0]         cols_r, rows_r;
	logic [31:0]        x_org, y_org;
	logic [30:0]        x_stp, y_stp;

	interp_result_t pending_q[$];
	int items_sent = 0;
	int mismatches = 0;
	bit gaps_on = 1'b1;

	function automatic longint clamp_l(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint bracket_axis(longint q, longint org, longint step, longint n,
			inout bit outside);
		longint d, fl, ce, lo, hi;
		d = q - org;
		fl = d / step;
		ce = fl;
		if (d % step != 0) begin
			if (d < 0) fl--;
			else ce++;
		end
		if (fl < 0 || ce > n - 1) outside = 1'b1;
		lo = clamp_l(fl, 0, n - 1);
		hi = clamp_l(ce, 0, n - 1);
		if (lo == hi && lo != 0) lo = hi - 1;
		return lo;
	endfunction

	function automatic interp_result_t predict_interp(logic signed [31:0] qx,
			logic signed [31:0] qy);
		interp_result_t r;
		longint nc, nr, xo, yo, sx, sy, i0, j0, lwx1, lwy1;
		logic signed [127:0] wx0, wx1, wy0, wy1, acc, den, quo;
		logic signed [31:0] s00, s01, s10, s11;
		logic [15:0] a00, a01, a10, a11;
		bit outside;
		bit sat;
		outside = 1'b0;
		nc = clamp_l(longint'(cols_r), 2, 256);
		nr = clamp_l(longint'(rows_r), 2, 256);
		xo = longint'($signed(x_org));
		yo = longint'($signed(y_org));
		sx = x_stp == 0 ? 1 : longint'(x_stp);
		sy = y_stp == 0 ? 1 : longint'(y_stp);
		i0 = bracket_axis(longint'(qx), xo, sx, nc, outside);
		j0 = bracket_axis(longint'(qy), yo, sy, nr, outside);
		lwx1 = longint'(qx) - (xo + i0 * sx);
		lwy1 = longint'(qy) - (yo + j0 * sy);
		wx1 = lwx1;
		wx0 = sx - lwx1;
		wy1 = lwy1;
		wy0 = sy - lwy1;
		a00 = 16'(j0 * nc + i0);
		a10 = 16'(j0 * nc + i0 + 1);
		a01 = 16'((j0 + 1) * nc + i0);
		a11 = 16'((j0 + 1) * nc + i0 + 1);
		s00 = grid_mem[a00];
		s01 = grid_mem[a01];
		s10 = grid_mem[a10];
		s11 = grid_mem[a11];
		acc = 128'(s00) * wx0 * wy0 + 128'(s01) * wx0 * wy1
			+ 128'(s10) * wx1 * wy0 + 128'(s11) * wx1 * wy1;
		den = 128'(sx) * 128'(sy);
		quo = acc / den;
		// round toward minus infinity
		if (acc % den != 0 && acc < 0) quo = quo - 1;
		sat = quo > 128'sd2147483647 || quo < -128'sd2147483648;
		if (sat) r.value = acc < 0 ? 32'sh80000000 : 32'sh7FFFFFFF;
		else r.value = quo[31:0];
		r.clamped = outside || sat;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// all calls start and end just after a rising edge
	task automatic send_item(logic m, logic [15:0] idx, logic [31:0] val,
			logic [31:0] qx, logic [31:0] qy);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		cell_index <= idx;
		cell_value <= val;
		query_x <= qx;
		query_y <= qy;
		do @(posedge clk); while (busy);
		items_sent++;
		if (m == MODE_LOAD) grid_mem[idx] = val;
		else pending_q.push_back(predict_interp(qx, qy));
	endtask

	task automatic load_cell(logic [15:0] idx, logic [31:0] val);
		send_item(MODE_LOAD, idx, val, $urandom, $urandom);
	endtask

	task automatic query_point(logic [31:0] qx, logic [31:0] qy);
		send_item(MODE_QUERY, 16'($urandom), $urandom, qx, qy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		// a trailing load may still be in the queue
		repeat (30) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_NUM_COLS: cols_r = data[8:0];
			CFG_NUM_ROWS: rows_r = data[8:0];
			CFG_X_ORIGIN: x_org = data;
			CFG_Y_ORIGIN: y_org = data;
			CFG_X_STEP:   x_stp = data[30:0];
			CFG_Y_STEP:   y_stp = data[30:0];
			default: ;
		endcase
	endtask

	task automatic write_geometry(logic [31:0] nc, logic [31:0] nr, logic [31:0] xo,
			logic [31:0] yo, logic [31:0] sx, logic [31:0] sy);
		cfg_write(CFG_NUM_COLS, nc);
		cfg_write(CFG_NUM_ROWS, nr);
		cfg_write(CFG_X_ORIGIN, xo);
		cfg_write(CFG_Y_ORIGIN, yo);
		cfg_write(CFG_X_STEP, sx);
		cfg_write(CFG_Y_STEP, sy);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF);
		endcase
	endfunction

	function automatic logic [31:0] pick_coord(longint org, longint step, longint n);
		longint k;
		k = $urandom_range(0, n - 2);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'(org + longint'($urandom_range(0, n - 1)) * step);
			2: return 32'(org - longint'($urandom_range(1, 1000)) * step / 7);
			3: return 32'(org + (n - 1) * step + longint'($urandom_range(1, 1000)) * step / 7);
			default: return 32'(org + k * step + longint'($urandom_range(0, step - 1)));
		endcase
	endfunction

	task automatic fill_grid();
		longint cells;
		cells = clamp_l(longint'(cols_r), 2, 256) * clamp_l(longint'(rows_r), 2, 256);
		for (longint c = 0; c < cells; c++) load_cell(16'(c), pick_sample());
	endtask

	task automatic test_directed();
		write_geometry(4, 3, 0, 0, 32'h10000, 32'h10000);
		cfg_write(CFG_BAD_IDX_A, 32'hFFFFFFFF);
		cfg_write(CFG_BAD_IDX_B, 32'h0);
		cfg_we <= 1'b0;
		@(posedge clk);
		load_cell(0, 32'h7FFFFFFF);
		load_cell(1, 32'h80000000);
		load_cell(2, 32'h00010000);
		load_cell(3, 32'hFFFF0000);
		for (int c = 4; c < 12; c++) load_cell(16'(c), 32'(c) << 16);
		query_point(32'h0, 32'h0);
		query_point(32'h30000, 32'h20000);
		query_point(32'h18000, 32'h18000);
		query_point(32'h10000, 32'h8000);
		query_point(32'hFFFB0000, 32'h4000);
		query_point(32'h7FFFFFFF, 32'h7FFFFFFF);
		query_point(32'h80000000, 32'h80000000);
		query_point(32'h2C000, 32'h80000000);
		query_point(32'h00001, 32'h1FFFF);
		wait_drained();
	endtask

	task automatic test_config_extremes();
		// zero steps act as one; counts out of range clamp; step bit 31 dropped
		write_geometry(0, 1, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h80000000);
		fill_grid();
		for (int n = 0; n < 6; n++)
			query_point(32'h7FFFFFFF + $urandom_range(0, 4), 32'h80000000 + $urandom_range(0, 4));
		wait_drained();
		write_geometry(511, 2, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		fill_grid();
		for (int n = 0; n < 8; n++) query_point($urandom, $urandom);
		wait_drained();
		write_geometry(2, 256, 0, 32'hFFFF0000, 32'h1, 32'h10000);
		fill_grid();
		for (int n = 0; n < 8; n++) query_point(pick_coord(0, 1, 2), pick_coord(-65536, 65536, 256));
		wait_drained();
	endtask

	task automatic test_random();
		longint nc, nr, xo, yo, sx, sy;
		int nq;
		logic [31:0] cfg_cols, cfg_rows, cfg_sx, cfg_sy;
		while (items_sent < 1750) begin
			case ($urandom_range(0, 9))
				0: cfg_cols = 511;
				1: cfg_cols = $urandom_range(0, 1);
				2: cfg_cols = 256;
				default: cfg_cols = $urandom_range(2, 12);
			endcase
			case ($urandom_range(0, 9))
				0: cfg_rows = 300;
				1: cfg_rows = $urandom_range(0, 1);
				default: cfg_rows = $urandom_range(2, 12);
			endcase
			if (clamp_l(cfg_cols[8:0], 2, 256) * clamp_l(cfg_rows[8:0], 2, 256) > GRID_CELL_CAP)
				cfg_rows = 2;
			case ($urandom_range(0, 7))
				0: cfg_sx = 32'h7FFFFFFF | ($urandom << 31);
				1: cfg_sx = $urandom_range(0, 1);
				2: cfg_sx = $urandom;
				default: cfg_sx = 32'h10000 * $urandom_range(1, 4) + $urandom_range(0, 9999);
			endcase
			case ($urandom_range(0, 7))
				0: cfg_sy = 32'h7FFFFFFF;
				1: cfg_sy = $urandom_range(0, 1);
				2: cfg_sy = $urandom;
				default: cfg_sy = 32'h8000 * $urandom_range(1, 4) + $urandom_range(0, 999);
			endcase
			write_geometry(cfg_cols, cfg_rows, $urandom_range(0, 3) == 0 ? $urandom : 32'h0,
				$urandom_range(0, 3) == 0 ? $urandom : 32'hFFF00000, cfg_sx, cfg_sy);
			gaps_on = $urandom_range(0, 3) != 0;
			fill_grid();
			nc = clamp_l(longint'(cols_r), 2, 256);
			nr = clamp_l(longint'(rows_r), 2, 256);
			xo = longint'($signed(x_org));
			yo = longint'($signed(y_org));
			sx = x_stp == 0 ? 1 : longint'(x_stp);
			sy = y_stp == 0 ? 1 : longint'(y_stp);
			nq = $urandom_range(10, 40);
			for (int n = 0; n < nq; n++) begin
				// stray loads anywhere in the store
				if ($urandom_range(0, 4) == 0) load_cell(16'($urandom), $urandom);
				else query_point(pick_coord(xo, sx, nc), pick_coord(yo, sy, nr));
			end
			wait_drained();
		end
	endtask

	always @(posedge clk) begin
		interp_result_t want;
		if (done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h clamped %b", interp_value, was_clamped);
			end else begin
				want = pending_q.pop_front();
				if (interp_value !== want.value || was_clamped !== want.clamped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %h clamped %b, got value %h clamped %b",
							want.value, want.clamped, interp_value, was_clamped);
				end
			end
		end
	end

	initial begin
		#40000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		cols_r = 256;
		rows_r = 256;
		x_org = 0;
		y_org = 0;
		x_stp = 31'h10000;
		y_stp = 31'h10000;
		for (int c = 0; c < STORE_DEPTH; c++) grid_mem[c] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		wait_drained();
		if (mismatches == 0 && pending_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> grid_bilinear_interpolator.f
design/gbi_pkg.sv
design/gbi_ram.sv
design/gbi_mul.sv
design/gbi_div.sv
design/gbi_front.sv
design/gbi_back.sv
design/grid_bilinear_interpolator.sv
tb/tb_top.sv
